// ----- sv/rita_pkg.sv -----
// Shared types and constants for the radix integer-to-ASCII converter.
// No dependencies; imported by the divider and the top level.
package rita_pkg;

  localparam int RADIX_W     = 5;  // width of the radix register
  localparam int REM_W       = 4;  // a remainder is below sixteen
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int CHARS_W     = 64; // eight characters per table word
  localparam int STEP_BITS   = 8;  // dividend bits consumed per divider cycle
  localparam int CFG_INDEX_W = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX      = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_OUT
  } state_t;

  // Sequencer to divider.
  typedef struct packed {
    logic load; // take a fresh dividend and start
    logic go;   // start again on the quotient held inside
  } div_ctrl_t;

  // Divider to sequencer.
  typedef struct packed {
    logic             done;      // one-cycle pulse, results below are valid
    logic [REM_W-1:0] rem;
    logic             quot_zero;
  } div_stat_t;

endpackage

// ----- sv/rita_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rita_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/rita_divider.sv -----
// Iterative divider by a small radix: eight dividend bits per cycle.
// Depends on rita_pkg. The quotient replaces the dividend in place.
module rita_divider #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rita_pkg::div_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0]           load_value,
  input  logic [rita_pkg::RADIX_W-1:0]     radix,
  output rita_pkg::div_stat_t              stat
);
  import rita_pkg::*;

  localparam int STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = STEPS * STEP_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic [PAD_W-1:0]     work;
  logic [REM_W-1:0]     rem;
  logic [STEP_W-1:0]    step;
  logic                 running;
  logic                 done;

  logic [STEP_BITS-1:0] chunk;
  logic [STEP_BITS-1:0] qbits;
  logic [REM_W-1:0]     rem_next;

  assign chunk = work[PAD_W-1 -: STEP_BITS];

  // Restoring division of one chunk; remainder stays below the radix.
  always_comb begin
    logic [RADIX_W-1:0] trial;
    logic [RADIX_W-1:0] diff;
    logic [REM_W-1:0]   r;
    r     = rem;
    qbits = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, chunk[i]};
      diff  = trial - radix;
      if (trial >= radix) begin
        r        = diff[REM_W-1:0];
        qbits[i] = 1'b1;
      end else begin
        r = trial[REM_W-1:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load || ctrl.go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= PAD_W'(load_value);
      rem  <= '0;
    end else if (ctrl.go) begin
      rem <= '0;
    end else if (running) begin
      work <= (work << STEP_BITS) | PAD_W'(qbits);
      rem  <= rem_next;
    end
  end

  assign stat.done      = done;
  assign stat.rem       = rem;
  assign stat.quot_zero = (work == '0);

endmodule

// ----- sv/radix_integer_to_ascii_top.sv -----
// Top level of the radix integer-to-ASCII converter: sequencer, registers,
// digit stack and character output. Depends on rita_pkg, rita_ram, rita_divider.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  -------------------------
//  input    start, busy, value                      word taken: start && !busy
//  config   cfg_valid, cfg_ready, cfg_index,        word taken: valid && ready
//           cfg_data                                (ready is always high)
//  result   strobe, character, last                 one cycle per word, no stall
//
// Each digit is one pass of the shared divider, which consumes eight dividend
// bits a cycle. Digits are pushed least significant first into a small RAM,
// then popped and emitted one a cycle, most significant first, through the
// RAM read register and the character lookup register. The edge that takes
// the last character of a word is also the first that can take the next word.
// Reset is synchronous, returns the sequencer to idle and sets the registers to radix 16
// and an all-zero character table. Busy stays high until the last read is out.
module radix_integer_to_ascii_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // input item
  input  logic                              start,
  output logic                              busy,
  input  logic [VALUE_WIDTH-1:0]            value,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rita_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rita_pkg::CHARS_W-1:0]      cfg_data,
  // results
  output logic                              strobe,
  output logic [rita_pkg::CHAR_W-1:0]       character,
  output logic                              last
);
  import rita_pkg::*;

  localparam int ADDR_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  // Registers
  logic [RADIX_W-1:0] radix;
  logic [CHARS_W-1:0] chars_low;
  logic [CHARS_W-1:0] chars_high;
  logic [RADIX_W-1:0] eff_radix;

  // Sequencer
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  ptr, ptr_next;
  div_ctrl_t          ctrl;
  div_stat_t          stat;
  logic               accept;

  // Digit stack
  logic               wr_en;
  logic               rd_en;
  logic               rd_last_next;
  logic [DIGIT_W-1:0] rd_data;
  logic               rd_valid;
  logic               rd_last;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE) || rd_valid;

  // Clamp the base into two to sixteen.
  always_comb begin
    if (radix < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      chars_low  <= '0;
      chars_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  chars_low  <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  rita_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .load_value(value),
    .radix     (eff_radix),
    .stat      (stat)
  );

  rita_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[ADDR_W-1:0]),
    .wr_data(stat.rem),
    .rd_en  (rd_en),
    .rd_addr(ptr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    ptr   <= ptr_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    ctrl         = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_last_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctrl.load  = 1'b1;
          count_next = '0;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // Push each remainder; stop once the quotient runs out.
        if (stat.done) begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
          if (stat.quot_zero) begin
            ptr_next   = count[ADDR_W-1:0];
            state_next = ST_OUT;
          end else begin
            ctrl.go = 1'b1;
          end
        end
      end
      ST_OUT: begin
        // Pop from the most significant digit down to digit zero.
        rd_en        = 1'b1;
        rd_last_next = (ptr == '0);
        if (ptr == '0) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr - 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Read latency stage, then character lookup into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      strobe   <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [CHARS_W-1:0] word;
    rd_last <= rd_last_next;
    last    <= rd_last;
    word = rd_data[DIGIT_W-1] ? chars_high : chars_low;
    character <= word[rd_data[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
  end

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_strobe_follows_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(rd_valid))
    else $error("result word without a preceding stack read");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> count <= CNT_W'(VALUE_WIDTH))
    else $error("digit count overflowed the stack");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIVIDE && busy)
    else $error("accepted word did not start a conversion");

endmodule
